// File: rtl/fqpr_pkg.sv
// Shared types and constants for the peekable, reversible FIFO queue.
package fqpr_pkg;

	localparam int REQ_W    = 2;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;
	localparam int STATUS_W = 2;
	localparam int WIDE_W   = 64;

	typedef enum logic [REQ_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_REV  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_read;
	} cmd_t;

	typedef struct packed {
		logic rd_hit;
	} stat_t;

endpackage

// File: rtl/fqpr_req_if.sv
// Request channel: valid/ready handshake carrying one queue request per beat.
interface fqpr_req_if;
	logic                        valid;
	logic                        ready;
	logic [fqpr_pkg::REQ_W-1:0]  req_type;
	logic [fqpr_pkg::DATA_W-1:0] data_in;
	logic [fqpr_pkg::IDX_W-1:0]  peek_index;

	modport source(output valid, req_type, data_in, peek_index, input ready);
	modport sink(input valid, req_type, data_in, peek_index, output ready);
endinterface

// File: rtl/fqpr_rsp_if.sv
// Response channel: valid/ready handshake carrying one result per beat.
interface fqpr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fqpr_pkg::DATA_W-1:0]   data_out;
	logic [fqpr_pkg::CNT_W-1:0]    queue_count;
	logic [fqpr_pkg::STATUS_W-1:0] status;

	modport source(output valid, data_out, queue_count, status, input ready);
	modport sink(input valid, data_out, queue_count, status, output ready);
endinterface

// File: rtl/fifo_queue_peek_reverse_unit.sv
// Top level of the peekable, reversible FIFO queue.
// Enqueue, reverse and any flagged request give their result in the cycle after the beat.
// Dequeue and peek give theirs through the registered store read port, then the result register.
// Throughput: one request per cycle while results are taken, but no new request during a store read.
// Reset: head, count and direction flag clear at once; the entry store is not cleared.
// No clearing pass: a request can be taken in the first cycle after reset.
module fifo_queue_peek_reverse_unit #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	fqpr_req_if.sink    req,
	fqpr_rsp_if.source  rsp
);

	fqpr_pkg::cmd_t  cmd;
	fqpr_pkg::stat_t stat;

	fqpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fqpr_datapath #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req.req_type),
		.data_in    (req.data_in),
		.peek_index (req.peek_index),
		.data_out   (rsp.data_out),
		.queue_count(rsp.queue_count),
		.status     (rsp.status)
	);

endmodule

// File: rtl/fqpr_ram.sv
// Generic single-port RAM with registered read data.
module fqpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/fqpr_datapath.sv
// Datapath: ring head pointer, count, direction flag, entry store and result register.
module fqpr_datapath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fqpr_pkg::cmd_t                cmd,
	output fqpr_pkg::stat_t               stat,
	input  logic [fqpr_pkg::REQ_W-1:0]    req_type,
	input  logic [fqpr_pkg::DATA_W-1:0]   data_in,
	input  logic [fqpr_pkg::IDX_W-1:0]    peek_index,
	output logic [fqpr_pkg::DATA_W-1:0]   data_out,
	output logic [fqpr_pkg::CNT_W-1:0]    queue_count,
	output logic [fqpr_pkg::STATUS_W-1:0] status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > fqpr_pkg::IDX_W) ? CW : fqpr_pkg::IDX_W;
	localparam logic [CW:0]   DEP_W = (CW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEP_C = CW'(DEPTH);

	logic [PW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rev_q, rev_d;

	logic [fqpr_pkg::DATA_W-1:0]   out_data_q;
	logic [fqpr_pkg::CNT_W-1:0]    out_cnt_q;
	fqpr_pkg::status_t             out_sts_q;
	fqpr_pkg::status_t             sts;

	fqpr_pkg::op_t    op;
	logic             full, empty, idx_ok, wr, rd;
	logic [IW-1:0]    idx_ext, cnt_ext;
	logic [PW-1:0]    addr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic [fqpr_pkg::WIDE_W-1:0] din_wide, rd_wide;
	logic [31:0]      cnt_wide;

	function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] head, input logic rev,
			input logic [CW-1:0] k);
		logic [CW:0] h;
		logic [CW:0] kk;
		logic [CW:0] s;
		h  = (CW + 1)'(head);
		kk = (CW + 1)'(k);
		if (rev) begin
			s = (h >= kk) ? (h - kk) : (h + DEP_W - kk);
		end else begin
			s = h + kk;
			if (s >= DEP_W) begin
				s = s - DEP_W;
			end
		end
		return s[PW-1:0];
	endfunction

	assign op      = fqpr_pkg::op_t'(req_type);
	assign full    = (cnt_q == DEP_C);
	assign empty   = (cnt_q == '0);
	assign idx_ext = IW'(peek_index);
	assign cnt_ext = IW'(cnt_q);
	assign idx_ok  = (idx_ext < cnt_ext);

	always_comb begin
		sts    = fqpr_pkg::STS_OK;
		head_d = head_q;
		cnt_d  = cnt_q;
		rev_d  = rev_q;
		wr     = 1'b0;
		rd     = 1'b0;
		addr   = head_q;
		unique case (op)
			fqpr_pkg::OP_ENQ: begin
				if (full) begin
					sts = fqpr_pkg::STS_FULL;
				end else begin
					wr    = 1'b1;
					addr  = slot_of(head_q, rev_q, cnt_q);
					cnt_d = cnt_q + CW'(1);
				end
			end
			fqpr_pkg::OP_DEQ: begin
				if (empty) begin
					sts = fqpr_pkg::STS_EMPTY;
				end else begin
					rd     = 1'b1;
					addr   = head_q;
					head_d = slot_of(head_q, rev_q, CW'(1));
					cnt_d  = cnt_q - CW'(1);
				end
			end
			fqpr_pkg::OP_PEEK: begin
				if (!idx_ok) begin
					sts = fqpr_pkg::STS_RANGE;
				end else begin
					rd   = 1'b1;
					addr = slot_of(head_q, rev_q, idx_ext[CW-1:0]);
				end
			end
			fqpr_pkg::OP_REV: begin
				if (!empty) begin
					head_d = slot_of(head_q, rev_q, cnt_q - CW'(1));
				end
				rev_d = ~rev_q;
			end
			default: begin
				sts = fqpr_pkg::STS_OK;
			end
		endcase
	end

	assign stat.rd_hit = rd;

	assign din_wide = fqpr_pkg::WIDE_W'(data_in);
	assign wdata    = din_wide[DATA_WIDTH-1:0];
	assign rd_wide  = fqpr_pkg::WIDE_W'(rdata);
	assign cnt_wide = 32'(cnt_d);

	fqpr_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.accept & wr),
		.re   (cmd.accept & rd),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			rev_q  <= 1'b0;
		end else if (cmd.accept) begin
			head_q <= head_d;
			cnt_q  <= cnt_d;
			rev_q  <= rev_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_data_q <= '0;
			out_cnt_q  <= cnt_wide[fqpr_pkg::CNT_W-1:0];
			out_sts_q  <= sts;
		end else if (cmd.load_read) begin
			out_data_q <= rd_wide[fqpr_pkg::DATA_W-1:0];
		end
	end

	assign data_out    = out_data_q;
	assign queue_count = out_cnt_q;
	assign status      = out_sts_q;

endmodule

// File: rtl/fqpr_ctrl.sv
// Controller: request acceptance, read wait state and result valid flag.
module fqpr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  fqpr_pkg::stat_t stat,
	output fqpr_pkg::cmd_t  cmd
);

	fqpr_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             accept;

	assign in_ready      = (state_q == fqpr_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign accept        = in_valid && in_ready;
	assign cmd.accept    = accept;
	assign cmd.load_read = (state_q == fqpr_pkg::S_READ);
	assign out_valid     = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqpr_pkg::S_IDLE: begin
				if (accept && stat.rd_hit) begin
					state_d = fqpr_pkg::S_READ;
				end
			end
			fqpr_pkg::S_READ: begin
				state_d = fqpr_pkg::S_IDLE;
			end
			default: begin
				state_d = fqpr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqpr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((accept && !stat.rd_hit) || (state_q == fqpr_pkg::S_READ)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_read_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fqpr_pkg::S_READ) |-> !out_valid_q)
		else $error("result pending during store read");

	a_read_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fqpr_pkg::S_READ) |=> (state_q == fqpr_pkg::S_IDLE) && out_valid_q)
		else $error("store read did not produce a result");

	a_direct_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !stat.rd_hit) |=> out_valid_q && (state_q == fqpr_pkg::S_IDLE))
		else $error("direct result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!out_valid_q || out_ready))
		else $error("accepted while result register occupied");
`endif

endmodule

// File: tb/tb.sv
// Self-checking bench for the peekable, reversible FIFO queue: directed table, then random traffic.
module tb;

	localparam int DEPTH       = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int N_RANDOM    = 650;
	localparam int DATA_W      = fqpr_pkg::DATA_W;
	localparam int CNT_W       = fqpr_pkg::CNT_W;
	localparam int IDX_W       = fqpr_pkg::IDX_W;

	typedef struct packed {
		logic [DATA_W-1:0]   data;
		logic [CNT_W-1:0]    count;
		fqpr_pkg::status_t   status;
	} rsp_beat_t;

	typedef struct {
		fqpr_pkg::op_t     op;
		logic [DATA_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		int                rep;
		bit                typed;
		rsp_beat_t         res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	fqpr_req_if req_ch();
	fqpr_rsp_if rsp_ch();

	fifo_queue_peek_reverse_unit #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// queue shadow
	logic [DATA_W-1:0] qm_ring [DEPTH];
	logic [IDX_W-1:0]  qm_head;
	logic [CNT_W-1:0]  qm_count;
	logic              qm_rev;

	rsp_beat_t  pending_results[$];
	stim_row_t  dir_rows[$];
	bit         calm     = 1'b0;
	bit         hold_rsp = 1'b0;
	int         n_mismatch, n_checked, n_items, n_holds, n_drains;
	int         n_op[4];
	int         n_full, n_empty, n_range;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] k);
		return qm_rev ? qm_head - k : qm_head + k;
	endfunction

	task automatic queue_model_step(input fqpr_pkg::op_t op, input logic [DATA_W-1:0] word,
			input logic [IDX_W-1:0] idx, output rsp_beat_t res);
		res = '{data: '0, count: '0, status: fqpr_pkg::STS_OK};
		case (op)
			fqpr_pkg::OP_ENQ: begin
				if (qm_count == DEPTH) begin
					res.status = fqpr_pkg::STS_FULL;
					n_full++;
				end else begin
					qm_ring[ring_slot(qm_count[IDX_W-1:0])] = word;
					qm_count++;
				end
			end
			fqpr_pkg::OP_DEQ: begin
				if (qm_count == 0) begin
					res.status = fqpr_pkg::STS_EMPTY;
					n_empty++;
				end else begin
					res.data = qm_ring[ring_slot('0)];
					qm_head = ring_slot(IDX_W'(1));
					qm_count--;
				end
			end
			fqpr_pkg::OP_PEEK: begin
				if (idx >= qm_count) begin
					res.status = fqpr_pkg::STS_RANGE;
					n_range++;
				end else begin
					res.data = qm_ring[ring_slot(idx)];
				end
			end
			default: begin
				if (qm_count != 0)
					qm_head = ring_slot(qm_count[IDX_W-1:0] - IDX_W'(1));
				qm_rev = ~qm_rev;
			end
		endcase
		res.count = qm_count;
		n_op[op]++;
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		n_mismatch++;
		if (n_mismatch <= 40)
			$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	task automatic add_row(input fqpr_pkg::op_t op, input logic [DATA_W-1:0] word,
			input logic [IDX_W-1:0] idx, input int rep, input bit typed,
			input logic [DATA_W-1:0] e_data, input logic [CNT_W-1:0] e_cnt,
			input fqpr_pkg::status_t e_sts);
		stim_row_t row;
		row.op = op;
		row.word = word;
		row.idx = idx;
		row.rep = rep;
		row.typed = typed;
		row.res = '{data: e_data, count: e_cnt, status: e_sts};
		dir_rows.push_back(row);
	endtask

	// one request beat; returns at the accepting edge
	task automatic offer(input fqpr_pkg::op_t op, input logic [DATA_W-1:0] word,
			input logic [IDX_W-1:0] idx, input bit typed, input rsp_beat_t typed_res);
		rsp_beat_t res;
		if (!calm && $urandom_range(99, 0) < 8) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= op;
		req_ch.data_in    <= word;
		req_ch.peek_index <= idx;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		queue_model_step(op, word, idx, res);
		if (typed)
			res = typed_res;
		pending_results.push_back(res);
		n_items++;
	endtask

	function automatic fqpr_pkg::op_t pick_op(input bit filling);
		int r;
		r = $urandom_range(99, 0);
		if (r < 22)
			return fqpr_pkg::OP_PEEK;
		if (r < 30)
			return fqpr_pkg::OP_REV;
		if (filling)
			return (r < 85) ? fqpr_pkg::OP_ENQ : fqpr_pkg::OP_DEQ;
		return (r < 85) ? fqpr_pkg::OP_DEQ : fqpr_pkg::OP_ENQ;
	endfunction

	// response side
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
				n_holds++;
			end
			rsp_ch.ready <= calm || ($urandom_range(99, 0) >= 8);
		end
	end

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", rsp_ch.data_out, '0);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (rsp_ch.data_out !== want.data)
					report_mismatch("data_out", rsp_ch.data_out, want.data);
				if (rsp_ch.queue_count !== want.count)
					report_mismatch("queue_count", DATA_W'(rsp_ch.queue_count),
						DATA_W'(want.count));
				if (rsp_ch.status !== want.status)
					report_mismatch("status", DATA_W'(rsp_ch.status), DATA_W'(want.status));
			end
		end
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		stim_row_t         row;
		fqpr_pkg::op_t     op;
		logic [DATA_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		bit                filling;
		int                r;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = fqpr_pkg::OP_ENQ;
		req_ch.data_in = '0;
		req_ch.peek_index = '0;
		qm_head = '0;
		qm_count = '0;
		qm_rev = 1'b0;
		for (int s = 0; s < DEPTH; s++)
			qm_ring[s] = '0;

		add_row(fqpr_pkg::OP_DEQ,  32'h0,        4'd0,  1,  1'b1, 32'h0,        5'd0,
			fqpr_pkg::STS_EMPTY);
		add_row(fqpr_pkg::OP_PEEK, 32'h0,        4'd0,  1,  1'b1, 32'h0,        5'd0,
			fqpr_pkg::STS_RANGE);
		add_row(fqpr_pkg::OP_REV,  32'h0,        4'd0,  1,  1'b1, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_ENQ,  32'hFFFFFFFF, 4'd15, 1,  1'b1, 32'h0,        5'd1,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_PEEK, 32'h0,        4'd0,  1,  1'b1, 32'hFFFFFFFF, 5'd1,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_PEEK, 32'h0,        4'd15, 1,  1'b1, 32'h0,        5'd1,
			fqpr_pkg::STS_RANGE);
		add_row(fqpr_pkg::OP_ENQ,  32'h01234567, 4'd0,  15, 1'b0, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_ENQ,  32'h0,        4'd0,  1,  1'b1, 32'h0,        5'd16,
			fqpr_pkg::STS_FULL);
		add_row(fqpr_pkg::OP_PEEK, 32'h0,        4'd15, 1,  1'b0, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_REV,  32'hFFFFFFFF, 4'd15, 1,  1'b1, 32'h0,        5'd16,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_PEEK, 32'h0,        4'd0,  1,  1'b0, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_DEQ,  32'h0,        4'd0,  1,  1'b0, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_ENQ,  32'h0,        4'd0,  1,  1'b1, 32'h0,        5'd16,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_PEEK, 32'h0,        4'd15, 1,  1'b0, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);
		add_row(fqpr_pkg::OP_DEQ,  32'h0,        4'd0,  3,  1'b0, 32'h0,        5'd0,
			fqpr_pkg::STS_OK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			for (int k = 0; k < row.rep; k++)
				offer(row.op, row.word + k * 32'h11111111, row.idx, row.typed, row.res);
		end

		filling = 1'b1;
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 200 && n < 350);
			if (n == 100)
				hold_rsp = 1'b1;
			if (n == 450) begin
				req_ch.valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
				n_drains++;
			end
			if (qm_count == DEPTH)
				filling = 1'b0;
			else if (qm_count == 0)
				filling = 1'b1;
			else if ($urandom_range(99, 0) < 3)
				filling = !filling;
			op = (n >= 100 && n < 130) ? fqpr_pkg::OP_ENQ : pick_op(filling);
			r = $urandom_range(9, 0);
			word = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
			if (qm_count != 0 && $urandom_range(9, 0) < 8)
				idx = IDX_W'($urandom_range(qm_count - 1, 0));
			else
				idx = IDX_W'($urandom_range(DEPTH - 1, 0));
			offer(op, word, idx, 1'b0, '0);
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests (enq %0d, deq %0d, peek %0d, rev %0d), %0d results checked",
			n_items, n_op[fqpr_pkg::OP_ENQ], n_op[fqpr_pkg::OP_DEQ],
			n_op[fqpr_pkg::OP_PEEK], n_op[fqpr_pkg::OP_REV], n_checked);
		$display("refusals: full %0d, empty %0d, peek range %0d; %0d long stalls, %0d drains",
			n_full, n_empty, n_range, n_holds, n_drains);
		if (n_mismatch == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
